### hw/rtl/double_ended_queue_assert.svh
// assertion macros for the double-ended queue
// each one samples on clk_i and is disabled while rst_ni is low
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// same-cycle implication
`define DBQ_ASSERT_IMM(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("double_ended_queue assertion failed");

// next-cycle implication
`define DBQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("double_ended_queue assertion failed");

`endif

### hw/rtl/dbq_pkg.sv
// ----------------------------------------------------------------------------
// dbq_pkg
// Operation codes and fixed port widths of the double-ended queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dbq_pkg;

  localparam int FuncW   = 3;
  localparam int IndexW  = 4;
  localparam int ValueW  = 32;
  localparam int CountOW = 5;

  localparam logic [FuncW-1:0] FUNC_PUSH_FRONT = 3'd0;
  localparam logic [FuncW-1:0] FUNC_PUSH_REAR  = 3'd1;
  localparam logic [FuncW-1:0] FUNC_POP_FRONT  = 3'd2;
  localparam logic [FuncW-1:0] FUNC_POP_REAR   = 3'd3;
  localparam logic [FuncW-1:0] FUNC_DELETE     = 3'd4;
  localparam logic [FuncW-1:0] FUNC_READ_INDEX = 3'd5;
  localparam logic [FuncW-1:0] FUNC_CLEAR      = 3'd6;

endpackage

### hw/rtl/dbq_ram.sv
// ----------------------------------------------------------------------------
// dbq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dbq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue kept in a ring RAM, one request per transaction.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake              payload
//  in       sink       in_valid_i/in_ready_o   func_i, value_i, index_i
//  out      source     out_valid_o/out_ready_i read_data_o, ok_o, front_value_o,
//                                              rear_value_o, count_o, empty_res_o
//
//  push, pop, clear: decode, front read, rear read, finish; a request that
//  leaves the queue empty skips the front and rear reads
//  read by index adds an index read; delete checks front, then rear, then scans
//  and shifts the middle: every step goes through the one ring RAM read port
//  reset clears state, count, front pointer and output valid, not the RAM
//  a result stalled on out_ready_i holds the finish step; no new request
//  is taken meanwhile
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "double_ended_queue_assert.svh"

module double_ended_queue #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [dbq_pkg::FuncW-1:0]     func_i,
  input  logic [dbq_pkg::ValueW-1:0]    value_i,
  input  logic [dbq_pkg::IndexW-1:0]    index_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [dbq_pkg::ValueW-1:0]    read_data_o,
  output logic                          ok_o,
  output logic [dbq_pkg::ValueW-1:0]    front_value_o,
  output logic [dbq_pkg::ValueW-1:0]    rear_value_o,
  output logic [dbq_pkg::CountOW-1:0]   count_o,
  output logic                          empty_res_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int DW = DATA_WIDTH;
  localparam int VW = dbq_pkg::ValueW;
  localparam int IW = dbq_pkg::IndexW;
  localparam int OW = dbq_pkg::CountOW;

  localparam logic [CW-1:0] DepthC = CW'(DEPTH);
  localparam logic [CW-1:0] OneC   = CW'(1);
  localparam logic [CW-1:0] TwoC   = CW'(2);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_RD_IDX = 4'd2;
  localparam logic [3:0] S_DEL_F  = 4'd3;
  localparam logic [3:0] S_DEL_R  = 4'd4;
  localparam logic [3:0] S_SCAN   = 4'd5;
  localparam logic [3:0] S_SHIFT  = 4'd6;
  localparam logic [3:0] S_RD_F   = 4'd7;
  localparam logic [3:0] S_RD_R   = 4'd8;
  localparam logic [3:0] S_RD_RW  = 4'd9;
  localparam logic [3:0] S_FINISH = 4'd10;

  // (a + b) mod DEPTH for a < DEPTH and b <= DEPTH
  function automatic logic [AW-1:0] add_mod(logic [AW-1:0] a, logic [CW-1:0] b);
    logic [CW:0] s;
    s = {{(CW + 1 - AW){1'b0}}, a} + {1'b0, b};
    if (s >= (CW + 1)'(DEPTH)) begin
      s = s - (CW + 1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  // control
  logic [3:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] front_q, front_d;
  logic          out_valid_q, out_valid_d;

  // payload
  logic [dbq_pkg::FuncW-1:0] func_q, func_d;
  logic [DW-1:0] val_q, val_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [CW-1:0] p_q, p_d;
  logic [AW-1:0] ws_q, ws_d;
  logic [AW-1:0] rs_q, rs_d;
  logic [DW-1:0] rd_q, rd_d;
  logic          ok_q, ok_d;
  logic [DW-1:0] fv_q, fv_d;
  logic [DW-1:0] rv_q, rv_d;
  logic [DW-1:0] o_rd_q, o_rd_d;
  logic          o_ok_q, o_ok_d;
  logic [DW-1:0] o_fv_q, o_fv_d;
  logic [DW-1:0] o_rv_q, o_rv_d;
  logic [CW-1:0] o_cnt_q, o_cnt_d;
  logic          o_empty_q, o_empty_d;

  // ram port
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [DW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [DW-1:0] ram_rdata;

  // width adaption
  logic [DW+VW-1:0] val_w;
  logic [DW-1:0]    val_in;
  logic [CW+IW-1:0] idx_w;
  logic [CW-1:0]    idx_c;
  logic             idx_ok;

  logic [AW-1:0] front_inc, front_dec, rear_slot, tail_slot, idx_slot, rs_inc;
  logic          hit, full, more;

  assign val_w  = {{DW{1'b0}}, value_i};
  assign val_in = val_w[DW-1:0];
  assign idx_w  = {{CW{1'b0}}, idx_q};
  assign idx_c  = idx_w[CW-1:0];
  assign idx_ok = idx_w < {{IW{1'b0}}, cnt_q};

  assign front_inc = add_mod(front_q, OneC);
  assign front_dec = add_mod(front_q, DepthC - OneC);
  assign rear_slot = add_mod(front_q, cnt_q - OneC);
  assign tail_slot = add_mod(front_q, cnt_q);
  assign idx_slot  = add_mod(front_q, idx_c);
  assign rs_inc    = add_mod(rs_q, OneC);

  assign hit  = ram_rdata == val_q;
  assign full = cnt_q == DepthC;
  // in scan, another middle position remains before the rear; in shift, another element remains to move
  assign more = (p_q + TwoC) < cnt_q;

  assign in_ready_o = state_q == S_IDLE;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    front_d     = front_q;
    out_valid_d = out_valid_q;
    func_d      = func_q;
    val_d       = val_q;
    idx_d       = idx_q;
    p_d         = p_q;
    ws_d        = ws_q;
    rs_d        = rs_q;
    rd_d        = rd_q;
    ok_d        = ok_q;
    fv_d        = fv_q;
    rv_d        = rv_q;
    o_rd_d      = o_rd_q;
    o_ok_d      = o_ok_q;
    o_fv_d      = o_fv_q;
    o_rv_d      = o_rv_q;
    o_cnt_d     = o_cnt_q;
    o_empty_d   = o_empty_q;
    ram_we      = 1'b0;
    ram_waddr   = ws_q;
    ram_wdata   = val_q;
    ram_raddr   = front_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          func_d  = func_i;
          val_d   = val_in;
          idx_d   = index_i;
          rd_d    = '0;
          ok_d    = 1'b0;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_RD_F;
        unique case (func_q)
          dbq_pkg::FUNC_PUSH_FRONT: begin
            if (!full) begin
              front_d   = front_dec;
              ram_we    = 1'b1;
              ram_waddr = front_dec;
              cnt_d     = cnt_q + OneC;
              ok_d      = 1'b1;
            end
          end
          dbq_pkg::FUNC_PUSH_REAR: begin
            if (!full) begin
              ram_we    = 1'b1;
              ram_waddr = tail_slot;
              cnt_d     = cnt_q + OneC;
              ok_d      = 1'b1;
            end
          end
          dbq_pkg::FUNC_POP_FRONT: begin
            if (cnt_q != '0) begin
              front_d = front_inc;
              cnt_d   = cnt_q - OneC;
              ok_d    = 1'b1;
            end
          end
          dbq_pkg::FUNC_POP_REAR: begin
            if (cnt_q != '0) begin
              cnt_d = cnt_q - OneC;
              ok_d  = 1'b1;
            end
          end
          dbq_pkg::FUNC_DELETE: begin
            if (cnt_q != '0) begin
              ram_raddr = front_q;
              state_d   = S_DEL_F;
            end
          end
          dbq_pkg::FUNC_READ_INDEX: begin
            if (idx_ok) begin
              ram_raddr = idx_slot;
              state_d   = S_RD_IDX;
            end
          end
          dbq_pkg::FUNC_CLEAR: begin
            cnt_d   = '0;
            front_d = '0;
            ok_d    = 1'b1;
          end
          default: begin
          end
        endcase
      end
      S_RD_IDX: begin
        rd_d    = ram_rdata;
        ok_d    = 1'b1;
        state_d = S_RD_F;
      end
      S_DEL_F: begin
        if (hit) begin
          front_d = front_inc;
          cnt_d   = cnt_q - OneC;
          ok_d    = 1'b1;
          state_d = S_RD_F;
        end else begin
          ram_raddr = rear_slot;
          state_d   = S_DEL_R;
        end
      end
      S_DEL_R: begin
        if (hit) begin
          cnt_d   = cnt_q - OneC;
          ok_d    = 1'b1;
          state_d = S_RD_F;
        end else if (TwoC < cnt_q) begin
          // middle scan starts at the second position
          p_d       = OneC;
          rs_d      = front_inc;
          ram_raddr = front_inc;
          state_d   = S_SCAN;
        end else begin
          state_d = S_RD_F;
        end
      end
      S_SCAN: begin
        rs_d      = rs_inc;
        ram_raddr = rs_inc;
        if (hit) begin
          ws_d    = rs_q;
          state_d = S_SHIFT;
        end else begin
          p_d = p_q + OneC;
          if (!more) begin
            state_d = S_RD_F;
          end
        end
      end
      S_SHIFT: begin
        // move the later element one place toward the front
        ram_we    = 1'b1;
        ram_waddr = ws_q;
        ram_wdata = ram_rdata;
        ws_d      = rs_q;
        rs_d      = rs_inc;
        ram_raddr = rs_inc;
        p_d       = p_q + OneC;
        if (!more) begin
          cnt_d   = cnt_q - OneC;
          ok_d    = 1'b1;
          state_d = S_RD_F;
        end
      end
      S_RD_F: begin
        ram_raddr = front_q;
        if (cnt_q == '0) begin
          fv_d    = '0;
          rv_d    = '0;
          state_d = S_FINISH;
        end else begin
          state_d = S_RD_R;
        end
      end
      S_RD_R: begin
        fv_d      = ram_rdata;
        ram_raddr = rear_slot;
        state_d   = S_RD_RW;
      end
      S_RD_RW: begin
        rv_d    = ram_rdata;
        state_d = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          o_rd_d      = rd_q;
          o_ok_d      = ok_q;
          o_fv_d      = fv_q;
          o_rv_d      = rv_q;
          o_cnt_d     = cnt_q;
          o_empty_d   = cnt_q == '0;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      front_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      front_q     <= front_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q    <= func_d;
    val_q     <= val_d;
    idx_q     <= idx_d;
    p_q       <= p_d;
    ws_q      <= ws_d;
    rs_q      <= rs_d;
    rd_q      <= rd_d;
    ok_q      <= ok_d;
    fv_q      <= fv_d;
    rv_q      <= rv_d;
    o_rd_q    <= o_rd_d;
    o_ok_q    <= o_ok_d;
    o_fv_q    <= o_fv_d;
    o_rv_q    <= o_rv_d;
    o_cnt_q   <= o_cnt_d;
    o_empty_q <= o_empty_d;
  end

  dbq_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // outputs show the low bits of an element
  logic [DW+VW-1:0] o_rd_w, o_fv_w, o_rv_w;
  logic [CW+OW-1:0] o_cnt_w;

  assign o_rd_w  = {{VW{1'b0}}, o_rd_q};
  assign o_fv_w  = {{VW{1'b0}}, o_fv_q};
  assign o_rv_w  = {{VW{1'b0}}, o_rv_q};
  assign o_cnt_w = {{OW{1'b0}}, o_cnt_q};

  assign out_valid_o   = out_valid_q;
  assign read_data_o   = o_rd_w[VW-1:0];
  assign ok_o          = o_ok_q;
  assign front_value_o = o_fv_w[VW-1:0];
  assign rear_value_o  = o_rv_w[VW-1:0];
  assign count_o       = o_cnt_w[OW-1:0];
  assign empty_res_o   = o_empty_q;

  // rear pop on a non-empty queue being decoded
  logic pop_rear_dec;
  assign pop_rear_dec = state_q == S_DECODE && func_q == dbq_pkg::FUNC_POP_REAR &&
                        cnt_q != '0;

  `DBQ_ASSERT_IMM(a_cnt_bound, 1'b1, cnt_q <= DepthC)
  `DBQ_ASSERT_IMM(a_scan_pos, state_q == S_SCAN || state_q == S_SHIFT, (p_q + OneC) < cnt_q)
  `DBQ_ASSERT_IMM(a_out_from_finish, $rose(out_valid_q), $past(state_q) == S_FINISH)
  `DBQ_ASSERT_NXT(a_pop_dec, pop_rear_dec, cnt_q == $past(cnt_q) - OneC)
  `DBQ_ASSERT_IMM(a_empty_match, out_valid_q, o_empty_q == (o_cnt_q == '0))

endmodule
